FILE: sv/scm_pkg.sv
`default_nettype none
package scm_pkg;

   localparam int VOICES     = 8;
   localparam int CHANNELS   = 8;
   localparam int TABLE_BITS = 8;
   localparam int TBL_N      = 1 << TABLE_BITS;
   localparam int FRAC_W     = 16 - TABLE_BITS;
   localparam int SAMPLE_W   = 16;
   localparam int SUM_W      = SAMPLE_W + $clog2(CHANNELS);
   localparam int MAG_W      = (SUM_W > 17) ? SUM_W : 17;
   localparam int TBL_W      = 31;
   localparam int STAGES     = 6;
   localparam logic [SAMPLE_W-1:0] FULL_SCALE = 16'h7FFF;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [TBL_W-1:0] tbl_entry_type;
   typedef tbl_entry_type tbl_type [0:TBL_N];

   typedef struct packed {
      logic abs_en;
      logic lut_en;
      logic interp_en;
      logic out_en;
   } tanh_ctl_type;

   // restoring long division, elaboration only
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] q;
      logic [64:0] r;
      q = '0;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[63:0], num[b]};
         if (r >= {1'b0, den}) begin
            r    = r - {1'b0, den};
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // tanh(4k/N) in unsigned Q.30 via e^(-8/N) series and repeated product
   function automatic tbl_type build_tanh_tbl();
      tbl_type     tbl;
      logic [63:0] t;
      logic [63:0] d60;
      logic [63:0] d32;
      logic [63:0] e;
      logic [63:0] one30;
      logic        done;
      t     = 64'd1 << 60;
      d60   = t;
      done  = 1'b0;
      one30 = 64'd1 << 30;
      e     = one30;
      for (int n = 1; n < 64; n++) begin
         if (!done) begin
            t = udiv64(t * 64'd8, 64'(TBL_N) * 64'(n));
            if (t == 64'd0) begin
               done = 1'b1;
            end else if (n[0]) begin
               d60 = d60 - t;
            end else begin
               d60 = d60 + t;
            end
         end
      end
      d32 = (d60 + (64'd1 << 27)) >> 28;
      for (int k = 0; k <= TBL_N; k++) begin
         if (k > 0) begin
            e = (e * d32 + (64'd1 << 31)) >> 32;
         end
         if (e > one30) begin
            e = one30;
         end
         tbl[k] = TBL_W'(udiv64((one30 - e) << 30, one30 + e));
      end
      return tbl;
   endfunction

   localparam tbl_type TANH_TBL = build_tanh_tbl();

endpackage
`default_nettype wire

FILE: sv/scm_lane.sv
`default_nettype none
module scm_lane (
   input  wire logic                 clock,
   input  wire logic                 en,
   input  wire logic                 present,
   input  wire scm_pkg::sample_type  sample,
   output scm_pkg::sample_type       masked_ff
);

   scm_pkg::sample_type masked_in;

   assign masked_in = present ? sample : '0;

   always_ff @(posedge clock) begin
      if (en) begin
         masked_ff <= masked_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/scm_merge.sv
`default_nettype none
module scm_merge (
   input  wire logic                          clock,
   input  wire logic                          en,
   input  wire scm_pkg::sample_type           lanes [scm_pkg::CHANNELS],
   output logic signed [scm_pkg::SUM_W-1:0]   sum_ff
);

   logic signed [scm_pkg::SUM_W-1:0] sum_in;

   always_comb begin
      sum_in = '0;
      for (int j = 0; j < scm_pkg::CHANNELS; j++) begin
         sum_in = sum_in + scm_pkg::SUM_W'(lanes[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff <= sum_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/scm_tanh.sv
`default_nettype none
module scm_tanh (
   input  wire logic                               clock,
   input  wire scm_pkg::tanh_ctl_type              ctl,
   input  wire logic signed [scm_pkg::SUM_W-1:0]   sum,
   output scm_pkg::sample_type                     sample_ff
);

   localparam int PROD_W  = scm_pkg::TBL_W + scm_pkg::FRAC_W;
   localparam int SCALE_W = scm_pkg::TBL_W + 15;

   // magnitude stage
   logic [scm_pkg::SUM_W-1:0] abs_w;
   logic [scm_pkg::MAG_W-1:0] mag_in, mag_ff;
   logic                      neg3_in, neg3_ff;

   assign neg3_in = sum[scm_pkg::SUM_W-1];
   assign abs_w   = neg3_in ? scm_pkg::SUM_W'(-sum) : scm_pkg::SUM_W'(sum);
   assign mag_in  = scm_pkg::MAG_W'(abs_w);

   always_ff @(posedge clock) begin
      if (ctl.abs_en) begin
         mag_ff  <= mag_in;
         neg3_ff <= neg3_in;
      end
   end

   // table stage
   logic [scm_pkg::TABLE_BITS:0]   idx_lo, idx_hi;
   scm_pkg::tbl_entry_type         lo_in, hi_w, diff_in, lo_ff, diff_ff;
   logic [scm_pkg::FRAC_W-1:0]     frac_in, frac_ff;
   logic                           sat4_in, sat4_ff, neg4_ff;

   assign sat4_in = |mag_ff[scm_pkg::MAG_W-1:16];
   assign idx_lo  = {1'b0, mag_ff[15:scm_pkg::FRAC_W]};
   assign idx_hi  = idx_lo + 1'b1;
   assign frac_in = mag_ff[scm_pkg::FRAC_W-1:0];
   assign lo_in   = scm_pkg::TANH_TBL[idx_lo];
   assign hi_w    = scm_pkg::TANH_TBL[idx_hi];
   assign diff_in = (hi_w >= lo_in) ? hi_w - lo_in : '0;

   always_ff @(posedge clock) begin
      if (ctl.lut_en) begin
         lo_ff   <= lo_in;
         diff_ff <= diff_in;
         frac_ff <= frac_in;
         sat4_ff <= sat4_in;
         neg4_ff <= neg3_ff;
      end
   end

   // interpolation stage
   logic [PROD_W-1:0]       prod_w;
   scm_pkg::tbl_entry_type  y_in, y_ff;
   logic                    sat5_ff, neg5_ff;

   assign prod_w = PROD_W'(diff_ff) * PROD_W'(frac_ff);
   assign y_in   = lo_ff + scm_pkg::TBL_W'(prod_w >> scm_pkg::FRAC_W);

   always_ff @(posedge clock) begin
      if (ctl.interp_en) begin
         y_ff    <= y_in;
         sat5_ff <= sat4_ff;
         neg5_ff <= neg4_ff;
      end
   end

   // scale by 0x7FFF as (y << 15) - y, clamp, apply sign
   logic [SCALE_W-1:0]          scaled_w;
   logic [15:0]                 m_w, mag_w;
   scm_pkg::sample_type         sample_in;

   assign scaled_w  = (SCALE_W'(y_ff) << 15) - SCALE_W'(y_ff);
   assign m_w       = scaled_w[45:30];
   assign mag_w     = (sat5_ff || (m_w > scm_pkg::FULL_SCALE)) ? scm_pkg::FULL_SCALE : m_w;
   assign sample_in = neg5_ff ? -$signed(mag_w) : $signed(mag_w);

   always_ff @(posedge clock) begin
      if (ctl.out_en) begin
         sample_ff <= sample_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/soft_clip_channel_mixer.sv
// Soft-clip channel mixer.
// Request channel (req_valid/req_ready): one transaction carries a signed
// Q2.14 sample per voice (req_voice_a..h), the mask of voices still sounding
// and the end-of-piece flag. Response channel (rsp_valid/rsp_ready): one
// transaction per request, tanh of the masked voice sum scaled to 0x7FFF and
// truncated towards zero, plus the copied end flag. Order is preserved.
// Pipeline stages: lane gating, merge adder, magnitude, tanh table read,
// interpolation, scaling and sign.
// Throughput: one transaction per cycle while rsp_ready holds, set by the
// six-stage pipeline with one lane per voice feeding a single merge adder.
// Every stage holds only while its successor is full and stalled, so empty
// stages keep filling while the response waits; req_ready drops only once
// all six stages hold transactions behind a stalled response.
// Reset (synchronous, active high) empties the pipeline; the tanh table is a
// constant and needs no loading. No transaction is dropped on a stall.
`default_nettype none
module soft_clip_channel_mixer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [15:0] req_voice_a,
   input  wire logic [15:0] req_voice_b,
   input  wire logic [15:0] req_voice_c,
   input  wire logic [15:0] req_voice_d,
   input  wire logic [15:0] req_voice_e,
   input  wire logic [15:0] req_voice_f,
   input  wire logic [15:0] req_voice_g,
   input  wire logic [15:0] req_voice_h,
   input  wire logic [7:0]  req_present_mask,
   input  wire logic        req_final_in,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_mixed_sample,
   output logic             rsp_final_out
);

   localparam int NS = scm_pkg::STAGES;

   // stage occupancy; stage k advances when empty or when k+1 advances
   logic [NS-1:0] valid_ff, valid_in, en;
   logic [NS-1:0] final_ff, final_in;

   always_comb begin
      en[NS-1] = !valid_ff[NS-1] || rsp_ready;
      for (int k = NS - 2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   always_comb begin
      for (int k = 0; k < NS; k++) begin
         if (en[k]) begin
            valid_in[k] = (k == 0) ? req_valid : valid_ff[(k == 0) ? 0 : k-1];
            final_in[k] = (k == 0) ? req_final_in : final_ff[(k == 0) ? 0 : k-1];
         end else begin
            valid_in[k] = valid_ff[k];
            final_in[k] = final_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      final_ff <= final_in;
   end

   assign req_ready     = en[0];
   assign rsp_valid     = valid_ff[NS-1];
   assign rsp_final_out = final_ff[NS-1];

   // one gating lane per voice
   scm_pkg::sample_type voices [scm_pkg::VOICES];
   scm_pkg::sample_type lanes  [scm_pkg::CHANNELS];

   assign voices[0] = req_voice_a;
   assign voices[1] = req_voice_b;
   assign voices[2] = req_voice_c;
   assign voices[3] = req_voice_d;
   assign voices[4] = req_voice_e;
   assign voices[5] = req_voice_f;
   assign voices[6] = req_voice_g;
   assign voices[7] = req_voice_h;

   for (genvar j = 0; j < scm_pkg::CHANNELS; j++) begin : g_lane
      scm_lane u_lane (
         .clock     (clock),
         .en        (en[0]),
         .present   (req_present_mask[j]),
         .sample    (voices[j]),
         .masked_ff (lanes[j])
      );
   end

   // merge the lanes into one sum
   logic signed [scm_pkg::SUM_W-1:0] sum;

   scm_merge u_merge (
      .clock  (clock),
      .en     (en[1]),
      .lanes  (lanes),
      .sum_ff (sum)
   );

   // soft clip
   scm_pkg::tanh_ctl_type tanh_ctl;
   scm_pkg::sample_type   mixed;

   assign tanh_ctl.abs_en    = en[2];
   assign tanh_ctl.lut_en    = en[3];
   assign tanh_ctl.interp_en = en[4];
   assign tanh_ctl.out_en    = en[5];

   scm_tanh u_tanh (
      .clock     (clock),
      .ctl       (tanh_ctl),
      .sum       (sum),
      .sample_ff (mixed)
   );

   assign rsp_mixed_sample = mixed;

endmodule
`default_nettype wire
